### rtl/dik_pkg.sv
// Shared constants, codes and controller/datapath interface types for the key set.
package dik_pkg;

  localparam int KEY_SPACE = 256;
  localparam int KEY_W     = 8;
  localparam int MODE_W    = 3;
  localparam int POS_W     = $clog2(KEY_SPACE);
  localparam int CNT_W     = $clog2(KEY_SPACE + 1);
  localparam int IDX_W     = POS_W + 1;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 3'd0,
    MODE_REMOVE = 3'd1,
    MODE_LOOKUP = 3'd2,
    MODE_CLEAR  = 3'd3,
    MODE_READ   = 3'd4
  } mode_e_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_SHIFT,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic capture;   // latch request, start table/list reads
    logic exec;      // perform operation on read data
    logic shift;     // one list compaction step
    logic load_out;  // move result into output register
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              present;  // key is a member
    logic              rm_more;  // entries above the gap need moving
    logic              sh_more;  // another compaction step follows
    logic              out_free; // output register can take a result
  } sts_t;

endpackage

### rtl/dense_indexed_key_set_core.sv
// Top level of the dense indexed key set: sequencer plus datapath.
//
// Ordered set of 8-bit keys. Members sit in a dense list in insertion order;
// a position table maps each key to its list slot. One request in, one
// result out, both on valid/ready channels.
//   in_mode: add, remove, lookup, clear, read at in_position.
//   Result: out_ok, out_index (slot of in_key after the op, -1 if absent),
//   out_key_at (read mode), out_count (members after the op).
// Requests are handled one at a time; in_ready is high only when idle.
// Each request is taken in ST_IDLE, executed in ST_LOOK and loaded into the
// output register from ST_RESP. A remove of a key with members above it
// passes through ST_SHIFT between them, moving one list entry down per step:
// the list memory's single read and write port sets that, so a remove at
// the head of a full set is the slowest request. No new request is taken
// while one is in flight; the next request is taken at best the cycle after
// the result is loaded.
// The result sits in an output register; the next request is taken while it
// waits. A stalled receiver holds the result, and a following result waits
// in the sequencer until the register frees up.
// Reset (synchronous, rst_n low) empties the set at once: membership flags
// and count clear, no sweep through the memories.
module dense_indexed_key_set_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [dik_pkg::MODE_W-1:0]        in_mode,
  input  logic [dik_pkg::KEY_W-1:0]         in_key,
  input  logic [7:0]                        in_position,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_ok,
  output logic signed [dik_pkg::IDX_W-1:0]  out_index,
  output logic [dik_pkg::KEY_W-1:0]         out_key_at,
  output logic [dik_pkg::CNT_W-1:0]         out_count
);

  // command/status between sequencer and datapath
  dik_pkg::cmd_t cmd;
  dik_pkg::sts_t sts;

  dik_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath latches the request itself on cmd.capture
  dik_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mode     (in_mode),
    .in_key      (in_key),
    .in_position (in_position),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_ok      (out_ok),
    .out_index   (out_index),
    .out_key_at  (out_key_at),
    .out_count   (out_count)
  );

endmodule

### rtl/dik_ctrl.sv
// Request sequencer for the key set: issues datapath commands per operation.
module dik_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  dik_pkg::sts_t sts,
  output dik_pkg::cmd_t cmd
);

  dik_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dik_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      dik_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = dik_pkg::ST_LOOK;
        end
      end
      dik_pkg::ST_LOOK: begin
        cmd.exec = 1'b1;
        if (sts.mode == dik_pkg::MODE_REMOVE && sts.present && sts.rm_more) begin
          state_nxt = dik_pkg::ST_SHIFT;
        end else begin
          state_nxt = dik_pkg::ST_RESP;
        end
      end
      dik_pkg::ST_SHIFT: begin
        cmd.shift = 1'b1;
        if (!sts.sh_more) begin
          state_nxt = dik_pkg::ST_RESP;
        end
      end
      dik_pkg::ST_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = dik_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dik_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/dik_dp.sv
// Key set datapath: member list and position table memories, count, output register.
module dik_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [dik_pkg::MODE_W-1:0]        in_mode,
  input  logic [dik_pkg::KEY_W-1:0]         in_key,
  input  logic [7:0]                        in_position,
  input  dik_pkg::cmd_t                     cmd,
  output dik_pkg::sts_t                     sts,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_ok,
  output logic signed [dik_pkg::IDX_W-1:0]  out_index,
  output logic [dik_pkg::KEY_W-1:0]         out_key_at,
  output logic [dik_pkg::CNT_W-1:0]         out_count
);

  localparam int POS_W = dik_pkg::POS_W;
  localparam int CNT_W = dik_pkg::CNT_W;
  localparam int IDX_W = dik_pkg::IDX_W;
  localparam int KEY_W = dik_pkg::KEY_W;
  localparam logic [IDX_W-1:0] IDX_NONE = {IDX_W{1'b1}};

  // memories
  logic [KEY_W-1:0] list_mem [dik_pkg::KEY_SPACE];
  logic [POS_W-1:0] tbl_mem  [dik_pkg::KEY_SPACE];
  logic [dik_pkg::KEY_SPACE-1:0] valid_r;

  // latched request
  logic [dik_pkg::MODE_W-1:0] mode_r;
  logic [KEY_W-1:0]           key_r;
  logic [7:0]                 pos_r;

  logic [KEY_W-1:0] list_q;
  logic [POS_W-1:0] tbl_q;
  logic             valid_q;

  logic [CNT_W-1:0] count_r;
  logic [POS_W-1:0] j_r;

  logic             res_ok_r;
  logic [IDX_W-1:0] res_index_r;
  logic [KEY_W-1:0] res_key_at_r;
  logic             res_ok_nxt;
  logic [IDX_W-1:0] res_index_nxt;
  logic [KEY_W-1:0] res_key_at_nxt;

  logic             out_valid_r;
  logic             out_ok_r;
  logic [IDX_W-1:0] out_index_r;
  logic [KEY_W-1:0] out_key_at_r;
  logic [CNT_W-1:0] out_count_r;

  logic             in_space;
  logic             present;
  logic             add_ok;
  logic             pos_ok;
  logic [POS_W-1:0] key_addr;
  logic [POS_W:0]   gap_p1;
  logic [POS_W:0]   j_p1;
  logic             list_rd_en;
  logic [POS_W-1:0] list_rd_addr;

  assign in_space = 32'(key_r) < 32'(dik_pkg::KEY_SPACE);
  assign key_addr = POS_W'(key_r);
  assign present  = valid_q && in_space;
  assign add_ok   = in_space && !valid_q && (count_r < CNT_W'(dik_pkg::KEY_SPACE));
  assign pos_ok   = CNT_W'(pos_r) < count_r;
  assign gap_p1   = {1'b0, tbl_q} + 1'b1;
  assign j_p1     = {1'b0, j_r} + 1'b1;

  assign sts.mode     = mode_r;
  assign sts.present  = present;
  assign sts.rm_more  = CNT_W'(gap_p1) < count_r;
  assign sts.sh_more  = CNT_W'(j_p1) < count_r;
  assign sts.out_free = !out_valid_r || out_ready;

  // list read port: requested position, then the entry above the gap, then one ahead
  always_comb begin
    list_rd_en   = 1'b0;
    list_rd_addr = POS_W'(in_position);
    if (cmd.capture) begin
      list_rd_en = 1'b1;
    end else if (cmd.exec) begin
      list_rd_en   = 1'b1;
      list_rd_addr = POS_W'(gap_p1);
    end else if (cmd.shift) begin
      list_rd_en   = 1'b1;
      list_rd_addr = POS_W'(j_p1 + 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (list_rd_en) begin
      list_q <= list_mem[list_rd_addr];
    end
    if (cmd.exec && mode_r == dik_pkg::MODE_ADD && add_ok) begin
      list_mem[POS_W'(count_r)] <= key_r;
    end else if (cmd.shift) begin
      list_mem[j_r] <= list_q;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tbl_q <= tbl_mem[POS_W'(in_key)];
    end
    if (cmd.exec && mode_r == dik_pkg::MODE_ADD && add_ok) begin
      tbl_mem[key_addr] <= POS_W'(count_r);
    end else if (cmd.shift) begin
      tbl_mem[POS_W'(list_q)] <= j_r;
    end
  end

  // result of the operation, taken on cmd.exec
  always_comb begin
    res_ok_nxt     = 1'b0;
    res_key_at_nxt = '0;
    res_index_nxt  = present ? {1'b0, tbl_q} : IDX_NONE;
    unique case (mode_r)
      dik_pkg::MODE_ADD: begin
        if (add_ok) begin
          res_ok_nxt    = 1'b1;
          res_index_nxt = {1'b0, POS_W'(count_r)};
        end
      end
      dik_pkg::MODE_REMOVE: begin
        res_ok_nxt    = present;
        res_index_nxt = IDX_NONE;
      end
      dik_pkg::MODE_LOOKUP: begin
        res_ok_nxt = present;
      end
      dik_pkg::MODE_CLEAR: begin
        res_ok_nxt    = 1'b1;
        res_index_nxt = IDX_NONE;
      end
      dik_pkg::MODE_READ: begin
        res_ok_nxt     = pos_ok;
        res_key_at_nxt = pos_ok ? list_q : '0;
      end
      default: begin
      end
    endcase
  end

  // request latch, gap walker, result hold
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r  <= in_mode;
      key_r   <= in_key;
      pos_r   <= in_position;
      valid_q <= valid_r[POS_W'(in_key)];
    end
    if (cmd.exec) begin
      j_r <= tbl_q;
    end else if (cmd.shift) begin
      j_r <= POS_W'(j_p1);
    end
    if (cmd.exec) begin
      res_ok_r     <= res_ok_nxt;
      res_index_r  <= res_index_nxt;
      res_key_at_r <= res_key_at_nxt;
    end
  end

  // membership flags and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else if (cmd.exec) begin
      unique case (mode_r)
        dik_pkg::MODE_ADD: begin
          if (add_ok) begin
            valid_r[key_addr] <= 1'b1;
            count_r           <= count_r + 1'b1;
          end
        end
        dik_pkg::MODE_REMOVE: begin
          if (present) begin
            valid_r[key_addr] <= 1'b0;
            count_r           <= count_r - 1'b1;
          end
        end
        dik_pkg::MODE_CLEAR: begin
          valid_r <= '0;
          count_r <= '0;
        end
        default: begin
        end
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_ok_r     <= res_ok_r;
      out_index_r  <= res_index_r;
      out_key_at_r <= res_key_at_r;
      out_count_r  <= count_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_ok     = out_ok_r;
  assign out_index  = $signed(out_index_r);
  assign out_key_at = out_key_at_r;
  assign out_count  = out_count_r;

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(dik_pkg::KEY_SPACE))
    else $error("member count beyond key space");

  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && mode_r == dik_pkg::MODE_CLEAR |=> count_r == '0 && valid_r == '0)
    else $error("clear left members behind");

  a_shift_in_list: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.shift |-> CNT_W'(j_r) < count_r)
    else $error("compaction step outside member list");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !out_valid_r || out_ready)
    else $error("result loaded over an untaken result");

endmodule

### verif/key_set_scoreboard_pkg.sv
// Scoreboard for the key set: membership predictor and store of pending results.
package key_set_scoreboard_pkg;

  typedef logic [dik_pkg::MODE_W-1:0]       sb_mode_t;
  typedef logic [dik_pkg::KEY_W-1:0]        sb_key_t;
  typedef logic signed [dik_pkg::IDX_W-1:0] sb_index_t;
  typedef logic [dik_pkg::CNT_W-1:0]        sb_count_t;

  typedef struct {
    int        req_no;
    logic      ok;
    sb_index_t index;
    sb_key_t   key_at;
    sb_count_t count;
  } set_result_t;

  class key_set_scoreboard;
    int          slot_of_key[dik_pkg::KEY_SPACE];  // -1 when absent
    sb_key_t     key_in_slot[dik_pkg::KEY_SPACE];
    int          members;
    set_result_t pending_results[$];
    int          req_count;
    int          failures;

    function new();
      foreach (slot_of_key[k]) slot_of_key[k] = -1;
      foreach (key_in_slot[s]) key_in_slot[s] = '0;
      members   = 0;
      req_count = 0;
      failures  = 0;
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("[%0t] %s", $time, msg);
    endfunction

    // Apply one accepted request to the predicted set and queue its result.
    function void note_request(sb_mode_t mode, sb_key_t key, logic [7:0] position);
      set_result_t r;
      int          gap;
      r.req_no = req_count++;
      r.ok     = 1'b0;
      r.key_at = '0;
      case (mode)
        dik_pkg::MODE_ADD: begin
          if (slot_of_key[key] < 0 && members < dik_pkg::KEY_SPACE) begin
            key_in_slot[members] = key;
            slot_of_key[key]     = members;
            members++;
            r.ok = 1'b1;
          end
        end
        dik_pkg::MODE_REMOVE: begin
          if (slot_of_key[key] >= 0) begin
            gap = slot_of_key[key];
            for (int s = gap; s + 1 < members; s++) key_in_slot[s] = key_in_slot[s+1];
            members--;
            slot_of_key[key] = -1;
            foreach (slot_of_key[k]) if (slot_of_key[k] > gap) slot_of_key[k]--;
            r.ok = 1'b1;
          end
        end
        dik_pkg::MODE_LOOKUP: r.ok = (slot_of_key[key] >= 0);
        dik_pkg::MODE_CLEAR: begin
          foreach (slot_of_key[k]) slot_of_key[k] = -1;
          members = 0;
          r.ok = 1'b1;
        end
        dik_pkg::MODE_READ: begin
          if (position < members) begin
            r.key_at = key_in_slot[position];
            r.ok     = 1'b1;
          end
        end
        default: ;
      endcase
      r.index = sb_index_t'(slot_of_key[key]);
      r.count = sb_count_t'(members);
      pending_results = {pending_results, r};
    endfunction

    function void check_result(logic ok, sb_index_t index, sb_key_t key_at,
                               sb_count_t count);
      set_result_t e;
      if (pending_results.size() == 0) begin
        note_failure($sformatf("unexpected result: ok=%0b index=%0d key_at=%0d count=%0d",
                               ok, index, key_at, count));
        return;
      end
      e = pending_results.pop_front();
      if (e.ok !== ok || e.index !== index || e.key_at !== key_at || e.count !== count)
        note_failure($sformatf({"request %0d: expected ok=%0b index=%0d key_at=%0d ",
                                "count=%0d, got ok=%0b index=%0d key_at=%0d count=%0d"},
                               e.req_no, e.ok, e.index, e.key_at, e.count,
                               ok, index, key_at, count));
    endfunction

    function int pending_count();
      return pending_results.size();
    endfunction
  endclass

endpackage

### verif/dense_indexed_key_set_core_tb.sv
// Testbench for dense_indexed_key_set_core: directed and biased random requests, scoreboarded.
module dense_indexed_key_set_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [dik_pkg::MODE_W-1:0] mode_t;
  typedef logic [dik_pkg::KEY_W-1:0]  key_t;
  typedef logic [7:0]                 pos_t;

  // Modes 5..7 have no operation; the block must leave the set alone.
  localparam mode_t MODE_SPARE_LO = 3'd5;
  localparam mode_t MODE_SPARE_HI = 3'd7;

  // Slowest legal run: ~1250 requests, each possibly a remove at the head of a
  // full set, plus random gaps and stalls. Take it several times.
  localparam int CYCLE_LIMIT = 2_000_000;
  // After the last result: longer than any single request's latency.
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              in_valid    = 1'b0;
  logic                              in_ready;
  mode_t                             in_mode     = '0;
  key_t                              in_key      = '0;
  pos_t                              in_position = '0;
  logic                              out_valid;
  logic                              out_ready   = 1'b0;
  logic                              out_ok;
  logic signed [dik_pkg::IDX_W-1:0]  out_index;
  logic [dik_pkg::KEY_W-1:0]         out_key_at;
  logic [dik_pkg::CNT_W-1:0]         out_count;

  key_set_scoreboard_pkg::key_set_scoreboard sb = new();

  // Stimulus-side view of membership, only used to steer keys and positions
  // toward hits. Checking never looks at it.
  bit in_set[dik_pkg::KEY_SPACE];
  int set_size = 0;

  bit idle_on = 1'b1;  // random gaps on both sides
  int stall_left = 0;
  int cycle_count = 0;

  always #10 clk = ~clk;

  dense_indexed_key_set_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_key      (in_key),
    .in_position (in_position),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_ok      (out_ok),
    .out_index   (out_index),
    .out_key_at  (out_key_at),
    .out_count   (out_count)
  );

  // Handshakes are sampled at the edge, before any nonblocking update lands,
  // so both the request and the result side see pre-edge values. A request
  // is noted before a result on the same edge; a result can never belong to
  // a request taken at that very edge anyway.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_request(in_mode, in_key, in_position);
      if (out_valid && out_ready) sb.check_result(out_ok, out_index, out_key_at, out_count);
    end
  end

  // Receiver: stalls out_ready in random bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 16);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Keep the steering view of the set in step with what was sent.
  function automatic void track_membership(mode_t mode, key_t key);
    case (mode)
      dik_pkg::MODE_ADD: begin
        if (!in_set[key]) begin
          in_set[key] = 1'b1;
          set_size++;
        end
      end
      dik_pkg::MODE_REMOVE: begin
        if (in_set[key]) begin
          in_set[key] = 1'b0;
          set_size--;
        end
      end
      dik_pkg::MODE_CLEAR: begin
        foreach (in_set[k]) in_set[k] = 1'b0;
        set_size = 0;
      end
      default: ;
    endcase
  endfunction

  // First key from a random start whose membership matches; random if none.
  function automatic key_t pick_key(bit want_member);
    int first;
    first = $urandom_range(0, dik_pkg::KEY_SPACE - 1);
    for (int i = 0; i < dik_pkg::KEY_SPACE; i++)
      if (in_set[(first + i) % dik_pkg::KEY_SPACE] == want_member)
        return key_t'((first + i) % dik_pkg::KEY_SPACE);
    return key_t'(first);
  endfunction

  // Present one request and hold it until taken. valid stays high across
  // back-to-back requests; it only drops when a gap is inserted.
  task automatic send_request(mode_t mode, key_t key, pos_t position);
    int gap;
    gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_key      <= key;
    in_position <= position;
    do @(posedge clk); while (!(in_valid && in_ready));
    track_membership(mode, key);
  endtask

  // Biased random requests. Weights are percentages; what is left over goes
  // to the unused modes. Adds mostly target absent keys and removes/lookups
  // mostly present ones, so the set actually grows, shrinks and shifts.
  task automatic run_phase(int n, int w_add, int w_rm, int w_look, int w_read, int w_clear);
    int   roll;
    key_t key;
    pos_t position;
    for (int i = 0; i < n; i++) begin
      roll     = $urandom_range(0, 99);
      key      = key_t'($urandom_range(0, dik_pkg::KEY_SPACE - 1));
      position = pos_t'($urandom_range(0, 255));
      if (roll < w_add) begin
        if ($urandom_range(0, 9) < 8) key = pick_key(1'b0);
        send_request(dik_pkg::MODE_ADD, key, position);
      end else if (roll < w_add + w_rm) begin
        if ($urandom_range(0, 3) != 0) key = pick_key(1'b1);
        send_request(dik_pkg::MODE_REMOVE, key, position);
      end else if (roll < w_add + w_rm + w_look) begin
        if ($urandom_range(0, 3) != 0) key = pick_key(1'b1);
        send_request(dik_pkg::MODE_LOOKUP, key, position);
      end else if (roll < w_add + w_rm + w_look + w_read) begin
        // Mostly in range, with the boundary slot (== size) now and then.
        if ($urandom_range(0, 4) != 0)
          position = pos_t'($urandom_range(0, (set_size > 255) ? 255 : set_size));
        send_request(dik_pkg::MODE_READ, key, position);
      end else if (roll < w_add + w_rm + w_look + w_read + w_clear) begin
        send_request(dik_pkg::MODE_CLEAR, key, position);
      end else begin
        send_request(mode_t'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI)), key, position);
      end
    end
  endtask

  initial begin
    // Hold synchronous reset low, then release it; the block empties the set at once.
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty set, extreme keys, a present add, a head remove that
    // shifts the list, a tail remove that does not, absent remove, reads
    // in and out of range, unused modes, and clear.
    send_request(dik_pkg::MODE_LOOKUP, 8'd0, 8'd0);
    send_request(dik_pkg::MODE_REMOVE, 8'd7, 8'd0);
    send_request(dik_pkg::MODE_READ, 8'd255, 8'd0);
    send_request(dik_pkg::MODE_READ, 8'd0, 8'd255);
    send_request(dik_pkg::MODE_ADD, 8'd0, 8'd0);
    send_request(dik_pkg::MODE_ADD, 8'd255, 8'd255);
    send_request(dik_pkg::MODE_ADD, 8'd128, 8'd0);
    send_request(dik_pkg::MODE_ADD, 8'd0, 8'd0);       // already a member
    send_request(dik_pkg::MODE_LOOKUP, 8'd255, 8'd0);
    send_request(dik_pkg::MODE_READ, 8'd0, 8'd0);
    send_request(dik_pkg::MODE_READ, 8'd128, 8'd2);
    send_request(dik_pkg::MODE_READ, 8'd255, 8'd3);    // one past the end
    send_request(dik_pkg::MODE_REMOVE, 8'd0, 8'd0);    // head: list shifts down
    send_request(dik_pkg::MODE_LOOKUP, 8'd255, 8'd0);
    send_request(dik_pkg::MODE_READ, 8'd0, 8'd1);
    send_request(dik_pkg::MODE_REMOVE, 8'd128, 8'd0);  // tail: no shift
    send_request(dik_pkg::MODE_REMOVE, 8'd128, 8'd0);  // now absent
    send_request(MODE_SPARE_LO, 8'd255, 8'd0);
    send_request(MODE_SPARE_LO + 3'd1, 8'd0, 8'd170);
    send_request(MODE_SPARE_HI, 8'd255, 8'd255);
    send_request(dik_pkg::MODE_CLEAR, 8'd255, 8'd0);
    send_request(dik_pkg::MODE_LOOKUP, 8'd255, 8'd0);
    send_request(dik_pkg::MODE_READ, 8'd0, 8'd0);
    send_request(dik_pkg::MODE_ADD, 8'd170, 8'd85);
    send_request(dik_pkg::MODE_CLEAR, 8'd85, 8'd170);

    // Grow toward a full set (count 256, slots up to 255), then mixed
    // traffic, then shrink with many removes that shift the list.
    run_phase(330, 88, 2, 3, 5, 0);
    run_phase(300, 34, 30, 12, 16, 2);
    run_phase(300, 18, 55, 10, 13, 1);

    // Last stretch at full rate on both sides.
    idle_on = 1'b0;
    run_phase(270, 38, 30, 12, 14, 2);
    in_valid <= 1'b0;

    while (sb.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.pending_count() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### dense_indexed_key_set_core.f
rtl/dik_pkg.sv
rtl/dik_ctrl.sv
rtl/dik_dp.sv
rtl/dense_indexed_key_set_core.sv
verif/key_set_scoreboard_pkg.sv
verif/dense_indexed_key_set_core_tb.sv
